>>> design/c2a_pkg.sv
// shared types, constants and setup functions for the color-to-alpha pixel unit
package c2a_pkg;

    localparam int FRAC_BITS = 16;
    localparam int AMT_W     = FRAC_BITS + 1;
    localparam int DNUM_W    = FRAC_BITS + 8;
    localparam int RNUM_W    = FRAC_BITS + 11;
    localparam int RDEN_W    = FRAC_BITS + 2;
    localparam int OUT_STEPS = 8;

    // pipeline positions: setup, amount divider, max, recolor setup, recolor divider
    localparam int AMT_LAT  = AMT_W;
    localparam int RC_LAT   = OUT_STEPS + 1;
    localparam int MAX_IDX  = AMT_LAT + 1;
    localparam int RC_IDX   = MAX_IDX + 1;
    localparam int LAST_IDX = RC_IDX + RC_LAT;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_RED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_GREEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BLUE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA  = 3'd3;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } pixel_out_t;

    typedef struct packed {
        logic [DNUM_W-1:0] num;
        logic [7:0]        den;
    } div_op_t;

    typedef struct packed {
        logic [RNUM_W-1:0] num;
        logic [RDEN_W-1:0] den;
    } rc_op_t;

    // numerator and divisor of one channel's removal amount, rounding offset included
    function automatic div_op_t amount_setup(input logic [7:0] s, input logic [7:0] k);
        div_op_t    op;
        logic [7:0] diff;
        diff   = '0;
        op.den = 8'd1;
        if (k == 8'd0)
        begin
            diff   = s;
            op.den = 8'd255;
        end
        else if (s > k)
        begin
            diff   = s - k;
            op.den = 8'd255 - k;
        end
        else if (s < k)
        begin
            diff   = k - s;
            op.den = k;
        end
        op.num = (DNUM_W'(diff) << FRAC_BITS) + DNUM_W'(op.den[7:1]);
        return op;
    endfunction

    // (2t + a) / (2a) with t = k*a + (s-k)*one; negative t gives a zero numerator
    function automatic rc_op_t recolor_setup(input logic [7:0] s, input logic [7:0] k,
                                             input logic [AMT_W-1:0] a);
        rc_op_t            op;
        logic [RNUM_W-1:0] sum;
        logic [RNUM_W-1:0] kk;
        logic [RNUM_W-1:0] t;
        sum = RNUM_W'(k) * RNUM_W'(a) + (RNUM_W'(s) << FRAC_BITS);
        kk  = RNUM_W'(k) << FRAC_BITS;
        t   = sum - kk;
        if (sum < kk)
            op.num = '0;
        else
            op.num = (t << 1) + RNUM_W'(a);
        op.den = {a, 1'b0};
        return op;
    endfunction

endpackage

>>> design/c2a_amount_div.sv
// pipelined restoring divider for one channel's removal amount, one quotient bit per stage
module c2a_amount_div (
    input  logic                     clk,
    input  logic                     advance,
    input  c2a_pkg::div_op_t         op,
    output logic [c2a_pkg::AMT_W-1:0] quo
);

    logic [c2a_pkg::DNUM_W-1:0] rem_reg [0:c2a_pkg::AMT_W-1];
    logic [7:0]                 den_reg [0:c2a_pkg::AMT_W-1];
    logic [c2a_pkg::AMT_W-1:0]  quo_reg [0:c2a_pkg::AMT_W-1];

    for (genvar j = 0; j < c2a_pkg::AMT_W; j++)
    begin : g_step
        localparam int SH = c2a_pkg::AMT_W - 1 - j;
        logic [c2a_pkg::DNUM_W-1:0] rem_in;
        logic [c2a_pkg::DNUM_W-1:0] sub;
        logic [7:0]                 den_in;
        logic [c2a_pkg::AMT_W-1:0]  quo_in;
        logic                       take;

        if (j == 0)
        begin : g_first
            assign rem_in = op.num;
            assign den_in = op.den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign sub  = c2a_pkg::DNUM_W'(den_in) << SH;
        assign take = (rem_in >= sub);

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[j] <= take ? (rem_in - sub) : rem_in;
                den_reg[j] <= den_in;
                quo_reg[j] <= {quo_in[c2a_pkg::AMT_W-2:0], take};
            end
        end
    end

    assign quo = quo_reg[c2a_pkg::AMT_W-1];

endmodule

>>> design/c2a_recolor_div.sv
// pipelined divider for a recolored channel: saturation check, then one bit per stage
module c2a_recolor_div (
    input  logic             clk,
    input  logic             advance,
    input  c2a_pkg::rc_op_t  op,
    output logic [7:0]       value
);

    localparam int N = c2a_pkg::OUT_STEPS + 1;

    logic [c2a_pkg::RNUM_W-1:0]    rem_reg [0:N-1];
    logic [c2a_pkg::RDEN_W-1:0]    den_reg [0:N-1];
    logic [c2a_pkg::OUT_STEPS-1:0] quo_reg [0:N-1];
    logic                          sat_reg [0:N-1];
    logic                          sat_next;

    // quotient of 256 or more clamps to full scale
    assign sat_next = op.num >= (c2a_pkg::RNUM_W'(op.den) << c2a_pkg::OUT_STEPS);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0] <= op.num;
            den_reg[0] <= op.den;
            quo_reg[0] <= '0;
            sat_reg[0] <= sat_next;
        end
    end

    for (genvar j = 1; j < N; j++)
    begin : g_step
        localparam int SH = c2a_pkg::OUT_STEPS - j;
        logic [c2a_pkg::RNUM_W-1:0] sub;
        logic                       take;

        assign sub  = c2a_pkg::RNUM_W'(den_reg[j-1]) << SH;
        assign take = (rem_reg[j-1] >= sub);

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[j] <= take ? (rem_reg[j-1] - sub) : rem_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                quo_reg[j] <= {quo_reg[j-1][c2a_pkg::OUT_STEPS-2:0], take};
                sat_reg[j] <= sat_reg[j-1];
            end
        end
    end

    assign value = sat_reg[N-1] ? 8'hFF : quo_reg[N-1];

endmodule

>>> design/color_to_alpha_pixel_unit.sv
// color-to-alpha pixel unit: top level pipeline, configuration registers and output register
//
// Removes a key color from a stream of 8-bit RGBA pixels, turning it into transparency.
// Source channel: src_valid / src_stall / src_data, one pixel per beat.
// Result channel: dst_valid / dst_stall / dst_data, one pixel per beat, same order.
// Configuration: cfg_write with cfg_index and cfg_data sets the key color channels and the
// alpha-present flag; write only while no pixel is in flight.
// Throughput is one pixel per cycle while the receiver does not stall: the three removal
// amounts go through a 17-stage restoring divider, one quotient bit per stage, and the
// recolored channels through a 9-stage divider (saturation check plus 8 quotient bits),
// all fully pipelined.
// The whole pipeline advances together; when the receiver stalls a waiting result, every
// stage holds and src_stall rises in the same cycle, so nothing is lost or repeated.
// Bubbles in the source stream travel as invalid stages and never reach dst_valid.
// Reset clears all stage valid bits and the output valid, and loads the key color white
// with the alpha-present flag set.
module color_to_alpha_pixel_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                src_valid,
    output logic                                src_stall,
    input  c2a_pkg::pixel_in_t                  src_data,
    output logic                                dst_valid,
    input  logic                                dst_stall,
    output c2a_pkg::pixel_out_t                 dst_data,
    input  logic                                cfg_write,
    input  logic [c2a_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [7:0]                          cfg_data
);

    localparam int LAST = c2a_pkg::LAST_IDX;
    localparam int AW   = c2a_pkg::AMT_W;

    logic [7:0] key_red_reg;
    logic [7:0] key_green_reg;
    logic [7:0] key_blue_reg;
    logic       has_alpha_reg;

    logic       advance;
    logic       vld_reg [0:LAST];
    logic       dst_valid_reg;
    c2a_pkg::pixel_out_t dst_data_reg;
    c2a_pkg::pixel_out_t dst_data_next;

    c2a_pkg::pixel_in_t  pix_reg [0:LAST];
    c2a_pkg::pixel_in_t  pix_next;
    c2a_pkg::div_op_t    amt_op_reg [0:2];
    logic [AW-1:0]       amt [0:2];
    logic [AW-1:0]       amax_reg;
    logic [AW-1:0]       amax_next;
    c2a_pkg::rc_op_t     rc_op_reg [0:2];
    logic [7:0]          rc_val [0:2];
    logic [AW+7:0]       alpha_prod;
    logic [7:0]          alpha_reg [c2a_pkg::RC_IDX:LAST];
    logic                zero_reg [c2a_pkg::RC_IDX:LAST];

    assign advance   = !(dst_valid_reg && dst_stall);
    assign src_stall = !advance;
    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_red_reg   <= 8'hFF;
            key_green_reg <= 8'hFF;
            key_blue_reg  <= 8'hFF;
            has_alpha_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                c2a_pkg::REG_KEY_RED:   key_red_reg   <= cfg_data;
                c2a_pkg::REG_KEY_GREEN: key_green_reg <= cfg_data;
                c2a_pkg::REG_KEY_BLUE:  key_blue_reg  <= cfg_data;
                c2a_pkg::REG_HAS_ALPHA: has_alpha_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
                vld_reg[i] <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= src_valid;
            for (int i = 1; i <= LAST; i++)
                vld_reg[i] <= vld_reg[i-1];
            dst_valid_reg <= vld_reg[LAST];
        end
    end

    // missing source alpha counts as opaque
    always_comb
    begin
        pix_next = src_data;
        if (!has_alpha_reg)
            pix_next.in_alpha = 8'hFF;
    end

    always_comb
    begin
        amax_next = amt[0];
        if (amt[1] > amax_next)
            amax_next = amt[1];
        if (amt[2] > amax_next)
            amax_next = amt[2];
    end

    assign alpha_prod = (AW+8)'(amax_reg) * (AW+8)'(pix_reg[c2a_pkg::MAX_IDX].in_alpha)
                      + ((AW+8)'(1) << (c2a_pkg::FRAC_BITS - 1));

    always_comb
    begin
        if (zero_reg[LAST])
        begin
            dst_data_next.out_red   = pix_reg[LAST].in_red;
            dst_data_next.out_green = pix_reg[LAST].in_green;
            dst_data_next.out_blue  = pix_reg[LAST].in_blue;
            dst_data_next.out_alpha = 8'd0;
        end
        else
        begin
            dst_data_next.out_red   = rc_val[0];
            dst_data_next.out_green = rc_val[1];
            dst_data_next.out_blue  = rc_val[2];
            dst_data_next.out_alpha = alpha_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pix_reg[0] <= pix_next;
            for (int i = 1; i <= LAST; i++)
                pix_reg[i] <= pix_reg[i-1];
            amt_op_reg[0] <= c2a_pkg::amount_setup(src_data.in_red,   key_red_reg);
            amt_op_reg[1] <= c2a_pkg::amount_setup(src_data.in_green, key_green_reg);
            amt_op_reg[2] <= c2a_pkg::amount_setup(src_data.in_blue,  key_blue_reg);
            amax_reg <= amax_next;
            rc_op_reg[0] <= c2a_pkg::recolor_setup(pix_reg[c2a_pkg::MAX_IDX].in_red,
                                                   key_red_reg, amax_reg);
            rc_op_reg[1] <= c2a_pkg::recolor_setup(pix_reg[c2a_pkg::MAX_IDX].in_green,
                                                   key_green_reg, amax_reg);
            rc_op_reg[2] <= c2a_pkg::recolor_setup(pix_reg[c2a_pkg::MAX_IDX].in_blue,
                                                   key_blue_reg, amax_reg);
            alpha_reg[c2a_pkg::RC_IDX] <=
                alpha_prod[c2a_pkg::FRAC_BITS+7:c2a_pkg::FRAC_BITS];
            zero_reg[c2a_pkg::RC_IDX] <= (amax_reg == '0);
            for (int i = c2a_pkg::RC_IDX + 1; i <= LAST; i++)
            begin
                alpha_reg[i] <= alpha_reg[i-1];
                zero_reg[i]  <= zero_reg[i-1];
            end
            dst_data_reg <= dst_data_next;
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        c2a_amount_div u_amount_div (
            .clk     (clk),
            .advance (advance),
            .op      (amt_op_reg[c]),
            .quo     (amt[c])
        );

        c2a_recolor_div u_recolor_div (
            .clk     (clk),
            .advance (advance),
            .op      (rc_op_reg[c]),
            .value   (rc_val[c])
        );
    end

    a_stall_matches: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall == (dst_valid_reg && dst_stall))
        else $error("source stall does not follow the output register");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |=> ($stable(vld_reg[0]) && $stable(vld_reg[LAST]) && $stable(amax_reg)))
        else $error("pipeline moved while stalled");

    a_amount_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[c2a_pkg::MAX_IDX] |-> (amax_reg <= (AW'(1) << c2a_pkg::FRAC_BITS)))
        else $error("removal amount above one");

endmodule

>>> sim/color_to_alpha_pixel_checker.sv
// checker for the color-to-alpha pixel unit: predicts each result beat and compares
module color_to_alpha_pixel_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    input  logic                 src_stall,
    input  c2a_pkg::pixel_in_t   src_data,
    input  logic                 dst_valid,
    input  logic                 dst_stall,
    input  c2a_pkg::pixel_out_t  dst_data,
    input  logic                 cfg_write,
    input  logic [c2a_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output int                   errors,
    output int                   pending
);

    localparam longint ONE = longint'(1) << c2a_pkg::FRAC_BITS;

    logic [7:0] key_r, key_g, key_b;
    logic       has_alpha;
    c2a_pkg::pixel_out_t expected_pixels[$];

    function automatic longint removal(input longint s, input longint k);
        if (k == 0)
            return (s * ONE + 127) / 255;
        if (s > k)
            return ((s - k) * ONE + (255 - k) / 2) / (255 - k);
        if (s < k)
            return ((k - s) * ONE + k / 2) / k;
        return 0;
    endfunction

    function automatic logic [7:0] shift_channel(input longint s, input longint k,
                                                 input longint a);
        longint t;
        longint r;
        t = k * a + (s - k) * ONE;
        if (t < 0)
            return 8'd0;
        r = (2 * t + a) / (2 * a);
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function automatic c2a_pkg::pixel_out_t predict_pixel(input c2a_pkg::pixel_in_t p);
        c2a_pkg::pixel_out_t o;
        longint a, ain, na;
        ain = has_alpha ? longint'(p.in_alpha) : 255;
        a = removal(p.in_red, key_r);
        if (removal(p.in_green, key_g) > a) a = removal(p.in_green, key_g);
        if (removal(p.in_blue, key_b) > a) a = removal(p.in_blue, key_b);
        if (a == 0)
        begin
            o = '{p.in_red, p.in_green, p.in_blue, 8'd0};
        end
        else
        begin
            o.out_red   = shift_channel(p.in_red, key_r, a);
            o.out_green = shift_channel(p.in_green, key_g, a);
            o.out_blue  = shift_channel(p.in_blue, key_b, a);
            na = (a * ain + (ONE / 2)) >> c2a_pkg::FRAC_BITS;
            o.out_alpha = (na > 255) ? 8'd255 : na[7:0];
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        c2a_pkg::pixel_out_t want;
        if (!rst_n)
        begin
            key_r = 8'd255;
            key_g = 8'd255;
            key_b = 8'd255;
            has_alpha = 1'b1;
            errors = 0;
            expected_pixels.delete();
            pending = 0;
        end
        else
        begin
            if (src_valid && !src_stall)
                expected_pixels.push_back(predict_pixel(src_data));
            if (dst_valid && !dst_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat %h", $time, dst_data);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (want.out_red !== dst_data.out_red
                        || want.out_green !== dst_data.out_green
                        || want.out_blue !== dst_data.out_blue
                        || want.out_alpha !== dst_data.out_alpha)
                    begin
                        errors++;
                        $display("%0t: mismatch expected %h actual %h", $time, want,
                                 dst_data);
                    end
                end
            end
            pending = expected_pixels.size();
            if (cfg_write)
            begin
                case (cfg_index)
                    c2a_pkg::REG_KEY_RED:   key_r = cfg_data;
                    c2a_pkg::REG_KEY_GREEN: key_g = cfg_data;
                    c2a_pkg::REG_KEY_BLUE:  key_b = cfg_data;
                    c2a_pkg::REG_HAS_ALPHA: has_alpha = cfg_data[0];
                    default: ;
                endcase
            end
        end
    end
endmodule

>>> sim/color_to_alpha_pixel_unit_tb.sv
// testbench top for the color-to-alpha pixel unit: stimulus, idling and verdict
module color_to_alpha_pixel_unit_tb;

    // indexes that name no register
    localparam logic [c2a_pkg::CFG_IDX_W-1:0] CFG_IDX_UNKNOWN_HI  = 3'd7;
    localparam logic [c2a_pkg::CFG_IDX_W-1:0] CFG_IDX_UNKNOWN_MID = 3'd5;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic src_valid = 1'b0;
    logic src_stall;
    c2a_pkg::pixel_in_t src_data = '0;
    logic dst_valid;
    logic dst_stall = 1'b0;
    c2a_pkg::pixel_out_t dst_data;
    logic cfg_write = 1'b0;
    logic [c2a_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    int errors, pending;
    int send_idle_pct = 11;
    int recv_idle_pct = 60;
    int hold_cycles = 0;

    always #4 clk = ~clk;

    color_to_alpha_pixel_unit DUT (.*);
    color_to_alpha_pixel_checker checker_i (.*);

    // receiver: random stall, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            dst_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            dst_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // valid stays high after the beat until the next pixel or a drain takes over
    task automatic send_pixel(input c2a_pkg::pixel_in_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= p;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain;
        src_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input logic [c2a_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_key(input logic [7:0] r, g, b, input logic [7:0] alpha_flag);
        drain();
        write_reg(c2a_pkg::REG_KEY_RED, r);
        write_reg(c2a_pkg::REG_KEY_GREEN, g);
        write_reg(c2a_pkg::REG_KEY_BLUE, b);
        write_reg(c2a_pkg::REG_HAS_ALPHA, alpha_flag);
    endtask

    // mostly near-key colors so the division paths see small and large amounts
    function automatic logic [7:0] near(input logic [7:0] k);
        int v;
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(255));
        v = int'(k) + int'($urandom_range(16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    task automatic random_run(input int count);
        c2a_pkg::pixel_in_t p;
        logic [7:0] kr, kg, kb;
        kr = 8'($urandom_range(255));
        kg = 8'($urandom_range(255));
        kb = 8'($urandom_range(255));
        set_key(kr, kg, kb, 8'($urandom_range(255)));
        for (int i = 0; i < count; i++)
        begin
            p.in_red   = near(kr);
            p.in_green = near(kg);
            p.in_blue  = near(kb);
            p.in_alpha = 8'($urandom_range(255));
            send_pixel(p);
        end
    endtask

    initial
    begin
        #200000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset key white, extremes and equal channels
        send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd255});
        send_pixel('{8'd0, 8'd128, 8'd255, 8'd0});
        send_pixel('{8'd254, 8'd255, 8'd255, 8'd77});
        // unknown index and excess bits
        set_key(8'd0, 8'd0, 8'd0, 8'hFE);
        write_reg(CFG_IDX_UNKNOWN_HI, 8'hAA);
        write_reg(CFG_IDX_UNKNOWN_MID, 8'h55);
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd10});
        send_pixel('{8'd255, 8'd0, 8'd1, 8'd10});
        send_pixel('{8'd1, 8'd2, 8'd3, 8'd200});
        set_key(8'd128, 8'd1, 8'd254, 8'd1);
        send_pixel('{8'd128, 8'd1, 8'd254, 8'd9});
        send_pixel('{8'd0, 8'd255, 8'd0, 8'd255});
        send_pixel('{8'd255, 8'd0, 8'd255, 8'd128});
        send_pixel('{8'd127, 8'd2, 8'd253, 8'd255});
        send_pixel('{8'd129, 8'd0, 8'd255, 8'd1});
        send_pixel('{8'd200, 8'd100, 8'd50, 8'd255});

        // long receiver hold-off while pixels keep coming
        send_idle_pct = 0;
        hold_cycles = 80;
        for (int i = 0; i < 50; i++)
            send_pixel(c2a_pkg::pixel_in_t'($urandom));
        drain();

        send_idle_pct = 11;
        recv_idle_pct = 60;
        repeat (4) random_run(60);
        send_idle_pct = 60;
        recv_idle_pct = 11;
        repeat (4) random_run(60);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) random_run(60);
        set_key(8'd255, 8'd255, 8'd255, 8'd1);
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> sim.f
design/c2a_pkg.sv
design/c2a_amount_div.sv
design/c2a_recolor_div.sv
design/color_to_alpha_pixel_unit.sv
sim/color_to_alpha_pixel_checker.sv
sim/color_to_alpha_pixel_unit_tb.sv
